// ===== hdl/addressed_frame_receiver_core_defines.svh =====
`ifndef ADDRESSED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define ADDRESSED_FRAME_RECEIVER_CORE_DEFINES_SVH

// Concurrent check that the consequent holds in the same cycle as the antecedent.
`define AFR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("afr check failed");

// Concurrent check that the consequent holds in the cycle after the antecedent.
`define AFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("afr check failed");

`endif

// ===== hdl/afr_pkg.sv =====
package afr_pkg;

    typedef enum logic [1:0] {
        FUNC_BYTE = 2'd0,
        FUNC_GAP  = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OWN     = 3'd0,
        ST_BCAST   = 3'd1,
        ST_SHORT   = 3'd2,
        ST_FOREIGN = 3'd3,
        ST_LENGTH  = 3'd4,
        ST_CKSUM   = 3'd5,
        ST_TIMEOUT = 3'd6,
        ST_UNUSED  = 3'd7
    } status_t;

    typedef enum logic {
        KIND_BODY   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef enum logic {
        REG_MY_ADDRESS    = 1'b0,
        REG_TIMEOUT_TICKS = 1'b1
    } reg_index_t;

    localparam logic [7:0]  DEFAULT_ADDRESS = 8'd254;
    localparam logic [7:0]  BCAST_ADDRESS   = 8'd0;
    localparam logic [7:0]  INVALID_ADDRESS = 8'hFF;
    localparam logic [15:0] TICK_MAX        = 16'hFFFF;
    localparam int          HEADER_BYTES    = 3;

endpackage

// ===== hdl/addressed_frame_receiver_core.sv =====
// Addressed frame receiver. Items on s_ carry a received byte, a line idle gap that ends
// the frame, or a millisecond tick. The first three bytes of a frame are the destination,
// the checksum and the body length; body bytes of frames for this node or for broadcast
// address zero come out on m_ at once as they arrive, and each frame end gives one status
// item that alone decides whether those bytes are good. Ticks counted while no frame has
// started give a timeout status when the count reaches a nonzero timeout_ticks. An item
// passes an input register and the update logic into the output register, so the block
// takes one item per clock unless stalled; m_ready low stalls the input only once both
// registers hold an item. Configuration is written through cfg_wr_en, cfg_index and
// cfg_wdata, by the user only while no item is in flight; the block does not enforce it.
module addressed_frame_receiver_core #(
    parameter int MAX_FRAME = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [7:0]  m_body_byte,
    output logic [6:0]  m_body_index,
    output logic [2:0]  m_status,
    output logic [7:0]  m_header_length
);

    localparam int CountWidth = $clog2(MAX_FRAME + 1);
    localparam logic [CountWidth-1:0] CountMax = CountWidth'(MAX_FRAME);

    logic [7:0]  my_address_reg;
    logic [15:0] timeout_ticks_reg;

    logic        in_valid_reg;
    logic [1:0]  in_func_reg;
    logic [7:0]  in_byte_reg;

    logic [CountWidth-1:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0]  dest_field_reg, dest_field_next;
    logic [7:0]  sum_field_reg, sum_field_next;
    logic [7:0]  length_field_reg, length_field_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic        overflow_reg, overflow_next;
    logic [15:0] wait_ticks_reg, wait_ticks_next;

    logic        out_valid_reg;
    logic        out_kind_reg, out_kind_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [6:0]  out_index_reg, out_index_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic [7:0]  out_length_reg, out_length_next;
    logic        emit;

    logic        advance;
    logic        addressed_here;
    logic [8:0]  pos_wide;
    logic [8:0]  body_pos;
    logic [15:0] wait_inc;
    logic [7:0]  addr_wdata;

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;

    assign addressed_here = (dest_field_reg == my_address_reg)
                         || (dest_field_reg == afr_pkg::BCAST_ADDRESS);
    assign pos_wide = 9'(bytes_seen_reg);
    assign body_pos = pos_wide - 9'(afr_pkg::HEADER_BYTES);
    assign wait_inc = (wait_ticks_reg == afr_pkg::TICK_MAX) ? wait_ticks_reg
                                                            : wait_ticks_reg + 16'd1;
    assign addr_wdata = cfg_wdata[7:0];

    always_comb begin
        bytes_seen_next   = bytes_seen_reg;
        dest_field_next   = dest_field_reg;
        sum_field_next    = sum_field_reg;
        length_field_next = length_field_reg;
        running_sum_next  = running_sum_reg;
        overflow_next     = overflow_reg;
        wait_ticks_next   = wait_ticks_reg;
        emit              = 1'b0;
        out_kind_next     = afr_pkg::KIND_BODY;
        out_byte_next     = 8'd0;
        out_index_next    = 7'd0;
        out_status_next   = afr_pkg::ST_OWN;
        out_length_next   = 8'd0;
        unique case (afr_pkg::func_t'(in_func_reg))
            afr_pkg::FUNC_BYTE: begin
                if (bytes_seen_reg == CountMax) begin
                    overflow_next = 1'b1;
                end else begin
                    bytes_seen_next = bytes_seen_reg + 1'b1;
                    if (pos_wide == 9'd0) begin
                        dest_field_next  = in_byte_reg;
                        running_sum_next = running_sum_reg + in_byte_reg;
                    end else if (pos_wide == 9'd1) begin
                        sum_field_next = in_byte_reg;
                    end else if (pos_wide == 9'd2) begin
                        length_field_next = in_byte_reg;
                        running_sum_next  = running_sum_reg + in_byte_reg;
                    end else begin
                        running_sum_next = running_sum_reg + in_byte_reg;
                        if (addressed_here) begin
                            emit            = 1'b1;
                            out_kind_next   = afr_pkg::KIND_BODY;
                            out_byte_next   = in_byte_reg;
                            out_index_next  = body_pos[6:0];
                            out_length_next = length_field_reg;
                        end
                    end
                end
            end
            afr_pkg::FUNC_GAP: begin
                if (pos_wide != 9'd0) begin
                    emit            = 1'b1;
                    out_kind_next   = afr_pkg::KIND_STATUS;
                    out_length_next = length_field_reg;
                    if (pos_wide < 9'(afr_pkg::HEADER_BYTES)) begin
                        out_status_next = afr_pkg::ST_SHORT;
                    end else if (!addressed_here) begin
                        out_status_next = afr_pkg::ST_FOREIGN;
                    end else if (overflow_reg || ({1'b0, length_field_reg} != body_pos)) begin
                        out_status_next = afr_pkg::ST_LENGTH;
                    end else if (sum_field_reg != running_sum_reg) begin
                        out_status_next = afr_pkg::ST_CKSUM;
                    end else if (dest_field_reg != afr_pkg::BCAST_ADDRESS) begin
                        out_status_next = afr_pkg::ST_OWN;
                    end else begin
                        out_status_next = afr_pkg::ST_BCAST;
                    end
                    bytes_seen_next   = '0;
                    dest_field_next   = 8'd0;
                    sum_field_next    = 8'd0;
                    length_field_next = 8'd0;
                    running_sum_next  = 8'd0;
                    overflow_next     = 1'b0;
                    wait_ticks_next   = 16'd0;
                end
            end
            afr_pkg::FUNC_TICK: begin
                if (pos_wide == 9'd0) begin
                    wait_ticks_next = wait_inc;
                    if ((timeout_ticks_reg != 16'd0) && (wait_inc >= timeout_ticks_reg)) begin
                        wait_ticks_next = 16'd0;
                        emit            = 1'b1;
                        out_kind_next   = afr_pkg::KIND_STATUS;
                        out_status_next = afr_pkg::ST_TIMEOUT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            my_address_reg    <= afr_pkg::DEFAULT_ADDRESS;
            timeout_ticks_reg <= 16'd0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            bytes_seen_reg    <= '0;
            dest_field_reg    <= 8'd0;
            sum_field_reg     <= 8'd0;
            length_field_reg  <= 8'd0;
            running_sum_reg   <= 8'd0;
            overflow_reg      <= 1'b0;
            wait_ticks_reg    <= 16'd0;
        end else begin
            if (cfg_wr_en) begin
                unique case (afr_pkg::reg_index_t'(cfg_index))
                    afr_pkg::REG_MY_ADDRESS: begin
                        if ((addr_wdata == afr_pkg::BCAST_ADDRESS)
                                || (addr_wdata == afr_pkg::INVALID_ADDRESS)) begin
                            my_address_reg <= afr_pkg::DEFAULT_ADDRESS;
                        end else begin
                            my_address_reg <= addr_wdata;
                        end
                    end
                    afr_pkg::REG_TIMEOUT_TICKS: begin
                        timeout_ticks_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg    <= emit;
                bytes_seen_reg   <= bytes_seen_next;
                dest_field_reg   <= dest_field_next;
                sum_field_reg    <= sum_field_next;
                length_field_reg <= length_field_next;
                running_sum_reg  <= running_sum_next;
                overflow_reg     <= overflow_next;
                wait_ticks_reg   <= wait_ticks_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg <= s_func;
            in_byte_reg <= s_rx_byte;
        end
        if (advance) begin
            out_kind_reg   <= out_kind_next;
            out_byte_reg   <= out_byte_next;
            out_index_reg  <= out_index_next;
            out_status_reg <= out_status_next;
            out_length_reg <= out_length_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_kind   = out_kind_reg;
    assign m_body_byte     = out_byte_reg;
    assign m_body_index    = out_index_reg;
    assign m_status        = out_status_reg;
    assign m_header_length = out_length_reg;

endmodule

// ===== hdl/afr_checker.sv =====
`include "addressed_frame_receiver_core_defines.svh"

module afr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_result_kind,
    input logic [7:0] m_body_byte,
    input logic [6:0] m_body_index,
    input logic [2:0] m_status,
    input logic [7:0] m_header_length
);

    `AFR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_body_byte) && $stable(m_status) && $stable(m_result_kind))
    `AFR_ASSERT_NOW(a_body_status_zero, aclk, aresetn,
        m_valid && (m_result_kind == afr_pkg::KIND_BODY), m_status == afr_pkg::ST_OWN)
    `AFR_ASSERT_NOW(a_status_no_byte, aclk, aresetn,
        m_valid && (m_result_kind == afr_pkg::KIND_STATUS),
        (m_body_byte == 8'd0) && (m_body_index == 7'd0) && (m_status != afr_pkg::ST_UNUSED))
    `AFR_ASSERT_NOW(a_timeout_no_length, aclk, aresetn,
        m_valid && (m_result_kind == afr_pkg::KIND_STATUS) && (m_status == afr_pkg::ST_TIMEOUT),
        m_header_length == 8'd0)

endmodule

bind addressed_frame_receiver_core afr_checker u_afr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_result_kind   (m_result_kind),
    .m_body_byte     (m_body_byte),
    .m_body_index    (m_body_index),
    .m_status        (m_status),
    .m_header_length (m_header_length)
);

// ===== sim/addressed_frame_receiver_core_checker.sv =====
`timescale 1ns / 100ps
module addressed_frame_receiver_core_checker #(
    parameter int MAX_FRAME = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_result_kind,
    input  logic [7:0]  m_body_byte,
    input  logic [6:0]  m_body_index,
    input  logic [2:0]  m_status,
    input  logic [7:0]  m_header_length,
    output int          error_count,
    output int          pending_count
);

    typedef struct packed {
        afr_pkg::kind_t   kind;
        logic [7:0]       body_byte;
        logic [6:0]       body_index;
        afr_pkg::status_t status;
        logic [7:0]       header_length;
    } rx_result_t;

    logic [7:0]  own_address;
    logic [15:0] timeout_limit;
    logic [7:0]  frame_bytes;
    logic [7:0]  frame_dest;
    logic [7:0]  sum_byte;
    logic [7:0]  len_byte;
    logic [7:0]  byte_sum;
    logic        frame_overflow;
    logic [15:0] idle_ticks;
    rx_result_t  expected_results[$];

    function automatic logic frame_is_ours();
        return frame_dest == own_address || frame_dest == afr_pkg::BCAST_ADDRESS;
    endfunction

    task automatic clear_frame_state();
        frame_bytes = '0;
        frame_dest = '0;
        sum_byte = '0;
        len_byte = '0;
        byte_sum = '0;
        frame_overflow = 1'b0;
        idle_ticks = '0;
    endtask

    task automatic predict_item(input logic [1:0] func_bits, input logic [7:0] rx);
        rx_result_t       r;
        afr_pkg::status_t st;
        logic [7:0]       pos;
        r = '0;
        pos = frame_bytes;
        case (afr_pkg::func_t'(func_bits))
            afr_pkg::FUNC_BYTE: begin
                if (pos >= MAX_FRAME) begin
                    frame_overflow = 1'b1;
                end else begin
                    frame_bytes = pos + 8'd1;
                    if (pos == 8'd0) begin
                        frame_dest = rx;
                        byte_sum = byte_sum + rx;
                    end else if (pos == 8'd1) begin
                        sum_byte = rx;
                    end else if (pos == 8'd2) begin
                        len_byte = rx;
                        byte_sum = byte_sum + rx;
                    end else begin
                        byte_sum = byte_sum + rx;
                        if (frame_is_ours()) begin
                            r.kind = afr_pkg::KIND_BODY;
                            r.body_byte = rx;
                            r.body_index = 7'(pos - afr_pkg::HEADER_BYTES);
                            r.status = afr_pkg::ST_OWN;
                            r.header_length = len_byte;
                            expected_results.push_back(r);
                        end
                    end
                end
            end
            afr_pkg::FUNC_GAP: begin
                if (frame_bytes != 8'd0) begin
                    if (frame_bytes < afr_pkg::HEADER_BYTES)
                        st = afr_pkg::ST_SHORT;
                    else if (!frame_is_ours())
                        st = afr_pkg::ST_FOREIGN;
                    else if (frame_overflow
                             || len_byte != 8'(frame_bytes - afr_pkg::HEADER_BYTES))
                        st = afr_pkg::ST_LENGTH;
                    else if (sum_byte != byte_sum)
                        st = afr_pkg::ST_CKSUM;
                    else if (frame_dest != afr_pkg::BCAST_ADDRESS)
                        st = afr_pkg::ST_OWN;
                    else
                        st = afr_pkg::ST_BCAST;
                    r.kind = afr_pkg::KIND_STATUS;
                    r.status = st;
                    r.header_length = len_byte;
                    expected_results.push_back(r);
                    clear_frame_state();
                end
            end
            afr_pkg::FUNC_TICK: begin
                if (frame_bytes == 8'd0) begin
                    if (idle_ticks != afr_pkg::TICK_MAX)
                        idle_ticks = idle_ticks + 16'd1;
                    if (timeout_limit != 16'd0 && idle_ticks >= timeout_limit) begin
                        idle_ticks = '0;
                        r.kind = afr_pkg::KIND_STATUS;
                        r.status = afr_pkg::ST_TIMEOUT;
                        expected_results.push_back(r);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin
        rx_result_t want;
        if (!aresetn) begin
            own_address = afr_pkg::DEFAULT_ADDRESS;
            timeout_limit = '0;
            clear_frame_state();
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected item, expected none actual kind %0d status %0d",
                             $time, m_result_kind, m_status);
                end else begin
                    want = expected_results.pop_front();
                    if (m_result_kind !== want.kind) begin
                        error_count++;
                        $display("%0t: result_kind expected %0d actual %0d",
                                 $time, want.kind, m_result_kind);
                    end
                    if (m_body_byte !== want.body_byte) begin
                        error_count++;
                        $display("%0t: body_byte expected %0d actual %0d",
                                 $time, want.body_byte, m_body_byte);
                    end
                    if (m_body_index !== want.body_index) begin
                        error_count++;
                        $display("%0t: body_index expected %0d actual %0d",
                                 $time, want.body_index, m_body_index);
                    end
                    if (m_status !== want.status) begin
                        error_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                    end
                    if (m_header_length !== want.header_length) begin
                        error_count++;
                        $display("%0t: header_length expected %0d actual %0d",
                                 $time, want.header_length, m_header_length);
                    end
                end
            end
            if (s_valid && s_ready)
                predict_item(s_func, s_rx_byte);
            if (cfg_wr_en) begin
                if (cfg_index == afr_pkg::REG_MY_ADDRESS) begin
                    if (cfg_wdata[7:0] == afr_pkg::BCAST_ADDRESS
                            || cfg_wdata[7:0] == afr_pkg::INVALID_ADDRESS)
                        own_address = afr_pkg::DEFAULT_ADDRESS;
                    else
                        own_address = cfg_wdata[7:0];
                end else begin
                    timeout_limit = cfg_wdata;
                end
            end
        end
        pending_count <= expected_results.size();
    end

endmodule

// ===== sim/tb_addressed_frame_receiver_core.sv =====
`timescale 1ns / 100ps
module tb_addressed_frame_receiver_core;

    localparam int MAX_FRAME = 128;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TOTAL_ITEMS = 1880;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_func;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_result_kind;
    logic [7:0]  m_body_byte;
    logic [6:0]  m_body_index;
    logic [2:0]  m_status;
    logic [7:0]  m_header_length;

    int          check_errors;
    int          results_pending;
    int          cycle_count = 0;
    int          items_sent = 0;
    bit          steady_send = 1'b0;
    bit          steady_recv = 1'b0;
    logic [7:0]  cur_address = afr_pkg::DEFAULT_ADDRESS;

    addressed_frame_receiver_core #(
        .MAX_FRAME(MAX_FRAME)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_body_byte    (m_body_byte),
        .m_body_index   (m_body_index),
        .m_status       (m_status),
        .m_header_length(m_header_length)
    );

    addressed_frame_receiver_core_checker #(
        .MAX_FRAME(MAX_FRAME)
    ) frame_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_body_byte    (m_body_byte),
        .m_body_index   (m_body_index),
        .m_status       (m_status),
        .m_header_length(m_header_length),
        .error_count    (check_errors),
        .pending_count  (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = steady_recv ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_item(input afr_pkg::func_t f, input logic [7:0] b);
        int gap;
        gap = steady_send ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_frame_bytes(input logic [7:0] frame_data[$], input int noise_at);
        for (int i = 0; i < frame_data.size(); i++) begin
            if (i == noise_at)
                send_item(($urandom_range(0, 1) == 0) ? afr_pkg::FUNC_TICK : afr_pkg::FUNC_NONE,
                          8'($urandom));
            send_item(afr_pkg::FUNC_BYTE, frame_data[i]);
        end
        send_item(afr_pkg::FUNC_GAP, 8'($urandom));
    endtask

    task automatic send_random_frame();
        logic [7:0] frame_data[$];
        logic [7:0] dest;
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] body_val;
        int         pick;
        int         body_len;
        int         noise_at;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            dest = cur_address;
        else if (pick < 70)
            dest = afr_pkg::BCAST_ADDRESS;
        else
            dest = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 90)
            body_len = $urandom_range(0, 12);
        else if (pick < 97)
            body_len = $urandom_range(13, MAX_FRAME - afr_pkg::HEADER_BYTES);
        else
            body_len = $urandom_range(MAX_FRAME - afr_pkg::HEADER_BYTES + 1, MAX_FRAME + 4);
        len = 8'(body_len);
        if ($urandom_range(0, 9) == 0)
            len = 8'($urandom);
        sum = dest + len;
        frame_data = '{dest, 8'd0, len};
        for (int i = 0; i < body_len; i++) begin
            body_val = 8'($urandom);
            sum = sum + body_val;
            frame_data.push_back(body_val);
        end
        if ($urandom_range(0, 9) == 0)
            sum = 8'($urandom);
        frame_data[1] = sum;
        if ($urandom_range(0, 19) == 0)
            frame_data = frame_data[0:$urandom_range(0, 2)];
        if ($urandom_range(0, 24) == 0)
            frame_data.delete();
        noise_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, frame_data.size()) : -1;
        send_frame_bytes(frame_data, noise_at);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input logic [7:0] addr, input logic [15:0] ticks);
        cfg_wr_en <= 1'b1;
        cfg_index <= afr_pkg::REG_MY_ADDRESS;
        cfg_wdata <= {8'($urandom), addr};
        @(posedge aclk);
        cfg_index <= afr_pkg::REG_TIMEOUT_TICKS;
        cfg_wdata <= ticks;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_address = (addr == afr_pkg::BCAST_ADDRESS || addr == afr_pkg::INVALID_ADDRESS)
                    ? afr_pkg::DEFAULT_ADDRESS : addr;
    endtask

    initial begin
        logic [7:0]  addr;
        logic [15:0] ticks;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= afr_pkg::REG_MY_ADDRESS;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_func <= afr_pkg::FUNC_BYTE;
        s_rx_byte <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(afr_pkg::FUNC_GAP, 8'h00);
        send_item(afr_pkg::FUNC_NONE, 8'hFF);
        send_item(afr_pkg::FUNC_TICK, 8'h00);
        send_frame_bytes('{afr_pkg::DEFAULT_ADDRESS, 8'hFF, 8'd2, 8'h00, 8'hFF}, 3);
        send_frame_bytes('{afr_pkg::BCAST_ADDRESS, 8'h00, 8'h00}, -1);
        send_frame_bytes('{afr_pkg::DEFAULT_ADDRESS}, -1);
        send_frame_bytes('{8'h55, 8'h00, 8'd1, 8'hAA}, -1);
        send_frame_bytes('{afr_pkg::DEFAULT_ADDRESS, 8'd2, 8'd3, 8'd1}, -1);
        send_frame_bytes('{afr_pkg::DEFAULT_ADDRESS, 8'h00, 8'h00}, -1);

        while (items_sent < TOTAL_ITEMS) begin
            wait_idle();
            case ($urandom_range(0, 5))
                0: addr = afr_pkg::BCAST_ADDRESS;
                1: addr = afr_pkg::INVALID_ADDRESS;
                2: addr = 8'd1;
                3: addr = afr_pkg::DEFAULT_ADDRESS;
                default: addr = 8'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: ticks = 16'd0;
                1: ticks = 16'd1;
                2: ticks = afr_pkg::TICK_MAX;
                3: ticks = 16'($urandom);
                default: ticks = 16'($urandom_range(2, 8));
            endcase
            configure(addr, ticks);
            steady_send = ($urandom_range(0, 3) == 0);
            steady_recv = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 10)) begin
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 6)) send_item(afr_pkg::FUNC_TICK, 8'($urandom));
                if ($urandom_range(0, 15) == 0)
                    send_item(afr_pkg::FUNC_NONE, 8'($urandom));
                send_random_frame();
            end
        end

        wait_idle();
        configure(8'($urandom_range(1, 254)), afr_pkg::TICK_MAX);
        send_item(afr_pkg::FUNC_TICK, 8'h00);
        send_item(afr_pkg::FUNC_TICK, 8'h00);

        wait_idle();
        repeat (8) @(posedge aclk);
        if (check_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/afr_pkg.sv
hdl/addressed_frame_receiver_core.sv
hdl/afr_checker.sv
sim/addressed_frame_receiver_core_checker.sv
sim/tb_addressed_frame_receiver_core.sv
